// File: rtl/dual_mode_pid_controller_macros.svh
// assertion macros for the pid controller
`ifndef DUAL_MODE_PID_CONTROLLER_MACROS_SVH
`define DUAL_MODE_PID_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, off during reset
`define DMPID_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DMPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DMPID_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define DMPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/dmpid_pkg.sv
package dmpid_pkg;

    // datapath sizes
    localparam int DATA_W    = 16;
    localparam int ACC_W     = 32;
    localparam int GAIN_W    = 16;
    localparam int OUT_MAX_W = 16;
    localparam int DRIVE_W   = 32;
    localparam int FRAC_W    = 8;

    localparam int ERR_W  = DATA_W + 1;
    localparam int DIF1_W = DATA_W + 2;
    localparam int DIF2_W = DATA_W + 3;
    localparam int PROD_W = GAIN_W + DIF2_W;
    localparam int SUM_W  = ((ACC_W > PROD_W + 2) ? ACC_W : PROD_W + 2) + 1;
    localparam int HI_W   = OUT_MAX_W + FRAC_W;
    localparam int CMP_W  = ((ACC_W > HI_W) ? ACC_W : HI_W) + 1;
    localparam int SHR_W  = ACC_W - FRAC_W;
    localparam int DEXT_W = (SHR_W > DRIVE_W) ? SHR_W : DRIVE_W;

    // apb port
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUT_MAX  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CLAMP_ON = 3'd5;

    typedef enum logic [1:0] {
        MODE_INC  = 2'd0,
        MODE_POS  = 2'd1,
        MODE_HOLD = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [OUT_MAX_W-1:0]      out_max;
        logic                      clamp_on;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err_prev;
        logic signed [ERR_W-1:0] err_prev2;
        logic signed [ACC_W-1:0] integ;
        logic signed [ACC_W-1:0] out_acc;
    } state_t;

endpackage

// File: rtl/dmpid_regs.sv
module dmpid_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmpid_pkg::ADDR_W-1:0]        paddr,
    input  logic [dmpid_pkg::PDATA_W-1:0]       pwdata,
    output logic [dmpid_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready,
    output dmpid_pkg::cfg_t                     cfg
);

    dmpid_pkg::cfg_t                       cfg_reg;
    dmpid_pkg::cfg_t                       cfg_next;
    logic                                  wr_en;
    logic [dmpid_pkg::REG_IDX_W-1:0]       idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[dmpid_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                dmpid_pkg::REG_MODE:     cfg_next.mode     = pwdata[1:0];
                dmpid_pkg::REG_GAIN_P:   cfg_next.gain_p   = pwdata[dmpid_pkg::GAIN_W-1:0];
                dmpid_pkg::REG_GAIN_I:   cfg_next.gain_i   = pwdata[dmpid_pkg::GAIN_W-1:0];
                dmpid_pkg::REG_GAIN_D:   cfg_next.gain_d   = pwdata[dmpid_pkg::GAIN_W-1:0];
                dmpid_pkg::REG_OUT_MAX:  cfg_next.out_max  = pwdata[dmpid_pkg::OUT_MAX_W-1:0];
                dmpid_pkg::REG_CLAMP_ON: cfg_next.clamp_on = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= dmpid_pkg::MODE_INC;
            cfg_reg.gain_p   <= '0;
            cfg_reg.gain_i   <= '0;
            cfg_reg.gain_d   <= '0;
            cfg_reg.out_max  <= '1;
            cfg_reg.clamp_on <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            dmpid_pkg::REG_MODE:     prdata = dmpid_pkg::PDATA_W'(cfg_reg.mode);
            dmpid_pkg::REG_GAIN_P:   prdata = dmpid_pkg::PDATA_W'($unsigned(cfg_reg.gain_p));
            dmpid_pkg::REG_GAIN_I:   prdata = dmpid_pkg::PDATA_W'($unsigned(cfg_reg.gain_i));
            dmpid_pkg::REG_GAIN_D:   prdata = dmpid_pkg::PDATA_W'($unsigned(cfg_reg.gain_d));
            dmpid_pkg::REG_OUT_MAX:  prdata = dmpid_pkg::PDATA_W'(cfg_reg.out_max);
            dmpid_pkg::REG_CLAMP_ON: prdata = dmpid_pkg::PDATA_W'(cfg_reg.clamp_on);
            default:                 prdata = '0;
        endcase
    end

endmodule

// File: rtl/dmpid_datapath.sv
module dmpid_datapath
(
    input  dmpid_pkg::cfg_t                           cfg,
    input  dmpid_pkg::state_t                         st,
    input  logic signed [dmpid_pkg::DATA_W-1:0]       setpoint,
    input  logic signed [dmpid_pkg::DATA_W-1:0]       measured,
    output dmpid_pkg::state_t                         st_next,
    output logic signed [dmpid_pkg::DRIVE_W-1:0]      drive_next
);

    localparam int ACC_W  = dmpid_pkg::ACC_W;
    localparam int SUM_W  = dmpid_pkg::SUM_W;
    localparam int CMP_W  = dmpid_pkg::CMP_W;
    localparam int DEXT_W = dmpid_pkg::DEXT_W;
    localparam int DRV_W  = dmpid_pkg::DRIVE_W;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-ACC_W:0] upper;
        logic signed [ACC_W-1:0] r;
        upper = v[SUM_W-1:ACC_W-1];
        if ((&upper) || !(|upper))
            r = v[ACC_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(ACC_W-1){1'b0}}};
        else
            r = {1'b0, {(ACC_W-1){1'b1}}};
        return r;
    endfunction

    logic signed [dmpid_pkg::ERR_W-1:0]   e0;
    logic signed [dmpid_pkg::DIF1_W-1:0]  d1;
    logic signed [dmpid_pkg::DIF2_W-1:0]  d2;
    logic signed [dmpid_pkg::DIF2_W-1:0]  op_p;
    logic signed [dmpid_pkg::DIF2_W-1:0]  op_d;
    logic signed [dmpid_pkg::PROD_W-1:0]  prod_p;
    logic signed [dmpid_pkg::PROD_W-1:0]  prod_i;
    logic signed [dmpid_pkg::PROD_W-1:0]  prod_d;
    logic                                 pos_mode;
    logic signed [SUM_W-1:0]              sum_inc;
    logic signed [SUM_W-1:0]              sum_integ;
    logic signed [ACC_W-1:0]              integ_pos;
    logic signed [SUM_W-1:0]              sum_pos;
    logic signed [ACC_W-1:0]              acc_upd;
    logic signed [ACC_W-1:0]              integ_upd;
    logic [dmpid_pkg::HI_W-1:0]           hi;
    logic signed [CMP_W-1:0]              acc_cmp;
    logic signed [CMP_W-1:0]              hi_cmp;
    logic signed [ACC_W-1:0]              acc_clamped;
    logic signed [DEXT_W-1:0]             drv_ext;
    logic [DEXT_W-DRV_W:0]                drv_upper;

    assign e0 = dmpid_pkg::ERR_W'(setpoint) - dmpid_pkg::ERR_W'(measured);
    assign d1 = dmpid_pkg::DIF1_W'(e0) - dmpid_pkg::DIF1_W'(st.err_prev);
    assign d2 = dmpid_pkg::DIF2_W'(e0) - (dmpid_pkg::DIF2_W'(st.err_prev) <<< 1)
              + dmpid_pkg::DIF2_W'(st.err_prev2);

    // three multipliers shared by both forms through operand muxes
    assign pos_mode = (cfg.mode == dmpid_pkg::MODE_POS);
    assign op_p     = pos_mode ? dmpid_pkg::DIF2_W'(e0) : dmpid_pkg::DIF2_W'(d1);
    assign op_d     = pos_mode ? dmpid_pkg::DIF2_W'(d1) : d2;
    assign prod_p   = cfg.gain_p * op_p;
    assign prod_i   = cfg.gain_i * e0;
    assign prod_d   = cfg.gain_d * op_d;

    assign sum_inc   = SUM_W'(st.out_acc) + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    assign sum_integ = SUM_W'(st.integ) + SUM_W'(prod_i);
    assign integ_pos = sat_acc(sum_integ);
    assign sum_pos   = SUM_W'(prod_p) + SUM_W'(integ_pos) + SUM_W'(prod_d);

    always_comb
    begin
        unique case (cfg.mode)
            dmpid_pkg::MODE_INC:
            begin
                acc_upd   = sat_acc(sum_inc);
                integ_upd = st.integ;
            end
            dmpid_pkg::MODE_POS:
            begin
                acc_upd   = sat_acc(sum_pos);
                integ_upd = integ_pos;
            end
            default:
            begin
                // hold, also the unused code
                acc_upd   = st.out_acc;
                integ_upd = st.integ;
            end
        endcase
    end

    assign hi      = {cfg.out_max, {dmpid_pkg::FRAC_W{1'b0}}};
    assign acc_cmp = CMP_W'(acc_upd);
    assign hi_cmp  = $signed(CMP_W'(hi));

    // upper limit first, then floor at zero
    always_comb
    begin
        acc_clamped = acc_upd;
        if (cfg.clamp_on)
        begin
            if (acc_cmp >= hi_cmp)
                acc_clamped = ACC_W'(hi);
            if (acc_clamped[ACC_W-1] || (acc_clamped == '0))
                acc_clamped = '0;
        end
    end

    // integer part, floor toward minus infinity
    assign drv_ext   = DEXT_W'($signed(acc_clamped[ACC_W-1:dmpid_pkg::FRAC_W]));
    assign drv_upper = drv_ext[DEXT_W-1:DRV_W-1];

    always_comb
    begin
        if ((&drv_upper) || !(|drv_upper))
            drive_next = drv_ext[DRV_W-1:0];
        else if (drv_ext[DEXT_W-1])
            drive_next = {1'b1, {(DRV_W-1){1'b0}}};
        else
            drive_next = {1'b0, {(DRV_W-1){1'b1}}};
    end

    always_comb
    begin
        st_next.err_prev  = e0;
        st_next.err_prev2 = st.err_prev;
        st_next.integ     = integ_upd;
        st_next.out_acc   = acc_clamped;
    end

endmodule

// File: rtl/dual_mode_pid_controller.sv
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------
// input     | in_valid / in_ready  | setpoint, measured (signed 16)
// output    | out_valid / out_ready| drive (signed 32)
// config    | apb, pready tied high| mode, gain_p/i/d, out_max, clamp_on
//
// one word per cycle sustained while out_ready is high; a word passes the input register, then the result register
// the rate is set by the state loop: error, three multiplies, accumulate, saturate
// and clamp all close combinationally from the state registers back to themselves
// rst_n clears handshake state, accumulators, error history and registers to defaults
// out_ready low holds the result; the input register then fills and in_ready drops
`include "dual_mode_pid_controller_macros.svh"

module dual_mode_pid_controller
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dmpid_pkg::ADDR_W-1:0]          paddr,
    input  logic [dmpid_pkg::PDATA_W-1:0]         pwdata,
    output logic [dmpid_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [dmpid_pkg::DATA_W-1:0]   setpoint,
    input  logic signed [dmpid_pkg::DATA_W-1:0]   measured,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dmpid_pkg::DRIVE_W-1:0]  drive
);

    dmpid_pkg::cfg_t                           cfg;
    dmpid_pkg::state_t                         st_reg;
    dmpid_pkg::state_t                         st_next;
    logic                                      in_valid_reg;
    logic                                      in_valid_next;
    logic signed [dmpid_pkg::DATA_W-1:0]       setpoint_reg;
    logic signed [dmpid_pkg::DATA_W-1:0]       measured_reg;
    logic                                      out_valid_reg;
    logic                                      out_valid_next;
    logic signed [dmpid_pkg::DRIVE_W-1:0]      drive_reg;
    logic signed [dmpid_pkg::DRIVE_W-1:0]      drive_next;
    logic                                      fire;

    dmpid_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmpid_datapath u_datapath
    (
        .cfg        (cfg),
        .st         (st_reg),
        .setpoint   (setpoint_reg),
        .measured   (measured_reg),
        .st_next    (st_next),
        .drive_next (drive_next)
    );

    // word in the input register moves on when the result slot is free
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign out_valid_next = fire ? 1'b1 : (out_valid_reg && !out_ready);

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            setpoint_reg <= setpoint;
            measured_reg <= measured;
        end
        if (fire)
            drive_reg <= drive_next;
    end

    `DMPID_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, in_valid_reg && out_valid_reg && !out_ready, "input stalled without a full pipeline")
    `DMPID_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, out_valid_reg, "processed word gave no result")
    `DMPID_ASSERT_NEXT(a_clamp_floor, clk, rst_n, fire && cfg.clamp_on, !st_reg.out_acc[dmpid_pkg::ACC_W-1], "clamped output went negative")
    `DMPID_ASSERT_NEXT(a_err_shift, clk, rst_n, fire, st_reg.err_prev2 == $past(st_reg.err_prev), "error history did not shift")
    `DMPID_ASSERT_NEXT(a_integ_hold, clk, rst_n, fire && (cfg.mode != dmpid_pkg::MODE_POS), $stable(st_reg.integ), "integral moved outside positional mode")

endmodule
